// ===== rtl/pulse_duration_capture_assert.svh =====
// Assertion macros for the pulse duration capture block.
// Expect clk and arst_n in the scope of each use.
`ifndef PULSE_DURATION_CAPTURE_ASSERT_SVH
`define PULSE_DURATION_CAPTURE_ASSERT_SVH

// same-cycle implication
`define PDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pdc_pkg.sv =====
// Shared types, codes and the half-period count step for pulse duration capture.
// No dependencies.
package pdc_pkg;

	localparam int unsigned DUR_W = 7;
	localparam logic [DUR_W-1:0] DUR_MASK = 7'h7F;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_HOLD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_DIVISOR       = 2'd0,
		REG_TIMEOUT_LIMIT = 2'd1,
		REG_START_LEVEL   = 2'd2,
		REG_CAPTURE_COUNT = 2'd3
	} reg_index_t;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_WAIT_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_HOLD_TIMEOUT = 2'd2;

	typedef struct packed {
		logic [7:0]  divisor;
		logic [15:0] timeout_limit;
		logic        start_level;
		logic [7:0]  capture_count;
	} cfg_t;

	typedef struct packed {
		logic [15:0]      sample;
		logic [7:0]       prescale;
		logic [DUR_W-1:0] scaled;
	} cnt_t;

	typedef struct packed {
		logic             ok;
		cnt_t             cnt;
	} step_t;

	typedef struct packed {
		logic [DUR_W-1:0] duration;
		logic [1:0]       status;
		logic [7:0]       captured;
		logic             last;
	} res_t;

	// count one sample of the running half-period; ok low on timeout
	function automatic step_t hold_step(cnt_t c, logic [7:0] divisor, logic [15:0] limit);
		step_t      r;
		logic [7:0] d;
		logic [7:0] p1;
		r.ok  = 1'b1;
		r.cnt = c;
		d     = (divisor == 8'd0) ? 8'd1 : divisor;
		p1    = c.prescale + 8'd1;
		if (c.sample > limit) begin
			r.ok = 1'b0;
		end else begin
			r.cnt.sample = c.sample + 16'd1;
			if (r.cnt.sample == 16'd0) begin
				r.cnt.prescale = 8'd0;
				r.cnt.scaled   = '0;
			end else if (p1 >= d) begin
				r.cnt.prescale = 8'd0;
				r.cnt.scaled   = (c.scaled + 7'd1) & DUR_MASK;
			end else begin
				r.cnt.prescale = p1;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/pdc_core.sv =====
// Run sequencer and half-period counters of the pulse duration capture block.
// Depends on pdc_pkg.
module pdc_core import pdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic start_req,
	input  logic level,
	input  cfg_t cfg,
	output logic res_valid,
	output res_t res,
	output logic idle
);

	phase_t     phase_q, phase_d;
	cnt_t       cnt_q, cnt_d;
	logic       held_q, held_d;
	logic [7:0] pulses_q, pulses_d;
	step_t      hs_run, hs_first;
	logic [7:0] pulses_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			held_q   <= 1'b0;
			pulses_q <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			held_q   <= held_d;
			pulses_q <= pulses_d;
		end
	end

	always_comb begin
		hs_run     = hold_step(cnt_q, cfg.divisor, cfg.timeout_limit);
		hs_first   = hold_step('0, cfg.divisor, cfg.timeout_limit);
		pulses_inc = pulses_q + 8'd1;
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		held_d     = held_q;
		pulses_d   = pulses_q;
		res_valid  = 1'b0;
		res        = '0;
		case (phase_q)
			PH_WAIT: begin
				if (level != held_q) begin
					if (cnt_q.sample > cfg.timeout_limit) begin
						phase_d      = PH_IDLE;
						res_valid    = 1'b1;
						res.status   = ST_WAIT_TIMEOUT;
						res.captured = pulses_q;
						res.last     = 1'b1;
					end else begin
						cnt_d.sample = cnt_q.sample + 16'd1;
					end
				end else if (cfg.capture_count == 8'd0) begin
					phase_d   = PH_IDLE;
					cnt_d     = '0;
					res_valid = 1'b1;
					res.last  = 1'b1;
				end else begin
					phase_d = PH_HOLD;
					cnt_d   = hs_first.cnt;
				end
			end
			PH_HOLD: begin
				if (level == held_q) begin
					if (!hs_run.ok) begin
						phase_d      = PH_IDLE;
						res_valid    = 1'b1;
						res.status   = ST_HOLD_TIMEOUT;
						res.captured = pulses_q;
						res.last     = 1'b1;
					end else begin
						cnt_d = hs_run.cnt;
					end
				end else begin
					pulses_d     = pulses_inc;
					res_valid    = 1'b1;
					res.duration = cnt_q.scaled;
					res.status   = ST_OK;
					res.captured = pulses_inc;
					res.last     = (pulses_inc >= cfg.capture_count);
					if (res.last) begin
						phase_d = PH_IDLE;
					end else begin
						held_d = ~held_q;
						cnt_d  = hs_first.cnt;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (start_req) begin
					phase_d  = PH_WAIT;
					cnt_d    = '0;
					pulses_d = 8'd0;
					held_d   = cfg.start_level;
				end
			end
		endcase
	end

	assign idle = (phase_q != PH_WAIT) && (phase_q != PH_HOLD);

endmodule

// ===== rtl/pulse_duration_capture.sv =====
// Top level of the pulse duration capture block: config registers, core, output register.
// Depends on pdc_pkg, pdc_core and pulse_duration_capture_assert.svh.
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  s_tdata: start_req, level
//  m_*      out        m_tvalid/m_tready  m_tdata: duration, status, captured; m_tlast: last
//  cfg_*    in         cfg_we             cfg_index, cfg_wdata
//
// One item per cycle; a result appears in the output register in the cycle after its item.
// Throughput is set by the single output register: s_tready drops only while it holds
// a result that m_tready does not take. Reset loads the register defaults and idles the run.
module pulse_duration_capture import pdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] start_req, [1] level, [7:2] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [6:0] duration, [8:7] status, [16:9] captured, [23:17] zero
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  out_valid_q;
	res_t  out_q;
	logic  step;
	logic  res_valid;
	res_t  res;
	logic  idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.divisor       <= 8'd1;
			cfg_q.timeout_limit <= 16'hFFFF;
			cfg_q.start_level   <= 1'b0;
			cfg_q.capture_count <= 8'd0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_DIVISOR:       cfg_q.divisor       <= cfg_wdata[7:0];
				REG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg_wdata;
				REG_START_LEVEL:   cfg_q.start_level   <= cfg_wdata[0];
				REG_CAPTURE_COUNT: cfg_q.capture_count <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	pdc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.start_req (s_tdata[0]),
		.level     (s_tdata[1]),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res),
		.idle      (idle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.captured, out_q.status, out_q.duration};
	assign m_tlast  = out_q.last;

	`include "pulse_duration_capture_assert.svh"

	`PDC_ASSERT_NOW(a_error_is_last, m_tvalid && (out_q.status != ST_OK), m_tlast, "error result without last")
	`PDC_ASSERT_NEXT(a_last_ends_run, step && res_valid && res.last, idle, "run still busy after last result")
	`PDC_ASSERT_NOW(a_idle_no_result, idle && step && !(res_valid == 1'b0), 1'b0, "result from idle core")

endmodule

// ===== tb/sv/pulse_duration_capture_tb.sv =====
// Self-checking testbench for pulse_duration_capture: streams line samples, predicts each
// duration and status result in step with accepted items, and compares them field by field.
// Depends on pdc_pkg and the pulse_duration_capture RTL.
module pulse_duration_capture_tb;
	import pdc_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_OFF    = 300;
	localparam int unsigned RANDOM_ITEMS = 1300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [0] start_req, [1] level
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [6:0] duration, [8:7] status, [16:9] captured
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	pulse_duration_capture i_dut (.*);

	always #10 clk = ~clk;

	// line samples waiting to be offered, and the results they are predicted to cause
	logic [7:0]  line_samples[$];
	res_t        pending_results[$];

	// predictor copy of the registers and of the capture state
	logic [7:0]  cfg_div = 8'd1;
	logic [15:0] cfg_limit = 16'hFFFF;
	logic        cfg_slvl = 1'b0;
	logic [7:0]  cfg_ccount = 8'd0;
	phase_t      run_phase = PH_IDLE;
	logic [15:0] smp_count = '0;
	logic [7:0]  pre_count = '0;
	logic [6:0]  dur_count = '0;
	logic        lvl_held = 1'b0;
	logic [7:0]  durs_done = '0;

	logic        idle_en = 1'b1;
	int          hold_reqs = 0;
	int          holds_seen;
	int unsigned hold_left;
	int unsigned src_gap;
	int unsigned sink_gap;
	int unsigned quiet = 0;
	int          errors = 0;
	int unsigned stim_items = 0;
	int unsigned results_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned timeouts = 0;

	function automatic int unsigned draw_gap();
		int unsigned roll;
		if (!idle_en)
			return 0;
		roll = $urandom_range(99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		if (roll < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// count one sample of the current half-period; low on timeout
	function automatic logic count_sample();
		logic [7:0] d;
		d = (cfg_div == 8'd0) ? 8'd1 : cfg_div;
		if (smp_count > cfg_limit)
			return 1'b0;
		smp_count = smp_count + 16'd1;
		if (smp_count == 16'd0) begin
			pre_count = '0;
			dur_count = '0;
		end else begin
			pre_count = pre_count + 8'd1;
			if (pre_count >= d) begin
				pre_count = '0;
				dur_count = dur_count + 7'd1;
			end
		end
		return 1'b1;
	endfunction

	function automatic void step_capture(logic start, logic lvl);
		res_t r;
		logic fire;
		r    = '0;
		fire = 1'b0;
		case (run_phase)
		PH_WAIT: begin
			if (lvl != lvl_held) begin
				if (smp_count > cfg_limit) begin
					run_phase  = PH_IDLE;
					r.status   = ST_WAIT_TIMEOUT;
					r.captured = durs_done;
					r.last     = 1'b1;
					fire       = 1'b1;
				end else begin
					smp_count = smp_count + 16'd1;
				end
			end else begin
				{smp_count, pre_count, dur_count} = '0;
				if (cfg_ccount == 8'd0) begin
					run_phase = PH_IDLE;
					r.status  = ST_OK;
					r.last    = 1'b1;
					fire      = 1'b1;
				end else begin
					run_phase = PH_HOLD;
					void'(count_sample());
				end
			end
		end
		PH_HOLD: begin
			if (lvl == lvl_held) begin
				if (!count_sample()) begin
					run_phase  = PH_IDLE;
					r.status   = ST_HOLD_TIMEOUT;
					r.captured = durs_done;
					r.last     = 1'b1;
					fire       = 1'b1;
				end
			end else begin
				durs_done  = durs_done + 8'd1;
				r.duration = dur_count;
				r.status   = ST_OK;
				r.captured = durs_done;
				r.last     = (durs_done >= cfg_ccount);
				fire       = 1'b1;
				if (r.last) begin
					run_phase = PH_IDLE;
				end else begin
					lvl_held = ~lvl_held;
					{smp_count, pre_count, dur_count} = '0;
					void'(count_sample());
				end
			end
		end
		default: begin
			run_phase = PH_IDLE;
			if (start) begin
				run_phase = PH_WAIT;
				{smp_count, pre_count, dur_count} = '0;
				durs_done = '0;
				lvl_held  = cfg_slvl;
			end
		end
		endcase
		if (fire) begin
			if (r.status != ST_OK)
				timeouts++;
			pending_results.push_back(r);
		end
	endfunction

	function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			if (errors < 100)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endfunction

	// offer line samples; predict each one at the edge that accepts it
	always @(posedge clk or negedge arst_n) begin : drive_samples
		logic       nxt_valid;
		logic [7:0] nxt_data;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  <= 0;
		end else begin
			nxt_valid = s_tvalid;
			nxt_data  = s_tdata;
			if (s_tvalid && s_tready) begin
				step_capture(s_tdata[0], s_tdata[1]);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
				end else if (line_samples.size() != 0) begin
					nxt_data  = line_samples.pop_front();
					nxt_valid = 1'b1;
					src_gap   <= draw_gap();
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata  <= nxt_data;
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		res_t want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			sink_gap   <= 0;
			hold_left  <= 0;
			holds_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected: expected nothing, got %h last %b",
						$time, m_tdata, m_tlast);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("duration", 16'(want.duration), 16'(m_tdata[6:0]));
					check_field("status", 16'(want.status), 16'(m_tdata[8:7]));
					check_field("captured", 16'(want.captured), 16'(m_tdata[16:9]));
					check_field("last", 16'(want.last), 16'(m_tlast));
				end
			end
			if (holds_seen != hold_reqs) begin
				holds_seen <= hold_reqs;
				hold_left  <= HOLD_OFF;
				m_tready   <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_gap <= draw_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (line_samples.size() == 0 && !s_tvalid && pending_results.size() == 0)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, quiet);
			$display("status: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic feed_one(logic start, logic lvl);
		line_samples.push_back({6'b0, lvl, start});
		stim_items++;
	endtask

	task automatic feed(logic start, logic lvl, int unsigned n);
		repeat (n) feed_one(start, lvl);
	endtask

	// drain the stream, then allow the output register to settle
	task automatic settle();
		while (line_samples.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_DIVISOR:       cfg_div    = val[7:0];
		REG_TIMEOUT_LIMIT: cfg_limit  = val;
		REG_START_LEVEL:   cfg_slvl   = val[0];
		REG_CAPTURE_COUNT: cfg_ccount = val[7:0];
		default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	function automatic int unsigned pick_len(int unsigned lenmax);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 80 || lenmax <= 2)
			return $urandom_range(lenmax, 1);
		if (roll < 97)
			return $urandom_range(4 * lenmax, 1);
		return $urandom_range(300, 60);
	endfunction

	// start, mismatched wait samples, then alternating half-periods and a closing edge
	task automatic push_run(int unsigned nwait, int unsigned nhalf, int unsigned lenmax);
		logic lvl;
		lvl = cfg_slvl;
		feed_one(1'b1, 1'($urandom_range(1)));
		repeat (nwait) feed_one(1'($urandom_range(1)), ~lvl);
		repeat (nhalf) begin
			repeat (pick_len(lenmax)) feed_one(1'($urandom_range(1)), lvl);
			lvl = ~lvl;
		end
		feed_one(1'($urandom_range(1)), lvl);
	endtask

	initial begin : stimulus
		int unsigned seg;
		int unsigned roll;
		int unsigned lenmax;
		int unsigned runs;
		int unsigned first_random;
		logic [15:0] dv;
		logic [15:0] tm;
		logic [15:0] cc;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero capture count at reset settings, with an idle sample ignored
		feed(1'b0, 1'b1, 1);
		feed(1'b1, 1'b1, 1);
		feed(1'b0, 1'b1, 1);
		feed(1'b1, 1'b0, 1);
		settle();
		write_reg(REG_DIVISOR, 16'd0);
		write_reg(REG_TIMEOUT_LIMIT, 16'd0);
		write_reg(REG_START_LEVEL, 16'd1);
		write_reg(REG_CAPTURE_COUNT, 16'd2);
		// wait timeout, then hold timeout
		feed(1'b1, 1'b0, 1);
		feed(1'b0, 1'b0, 2);
		feed(1'b1, 1'b1, 1);
		feed(1'b0, 1'b1, 2);
		settle();
		write_reg(REG_TIMEOUT_LIMIT, 16'hFFFF);
		write_reg(REG_DIVISOR, 16'd2);
		write_reg(REG_CAPTURE_COUNT, 16'd3);
		// two half-periods, start requests ignored while busy
		feed(1'b1, 1'b0, 2);
		feed(1'b1, 1'b1, 2);
		feed(1'b0, 1'b1, 2);
		feed(1'b0, 1'b0, 2);
		feed(1'b1, 1'b1, 1);
		settle();
		// divisor and capture count change in the middle of the run
		write_reg(REG_DIVISOR, 16'd1);
		write_reg(REG_CAPTURE_COUNT, 16'd1);
		feed(1'b0, 1'b1, 1);
		feed(1'b0, 1'b0, 1);
		settle();

		first_random = stim_items;
		seg = 0;
		while (stim_items - first_random < RANDOM_ITEMS) begin
			settle();
			roll = $urandom_range(9);
			dv = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd1 : (roll == 2) ? 16'd255 :
				(roll < 7) ? 16'($urandom_range(4, 2)) : 16'($urandom_range(255));
			roll = $urandom_range(9);
			tm = (roll == 0) ? 16'd0 : (roll < 3) ? 16'hFFFF :
				(roll < 7) ? 16'($urandom_range(12, 1)) : 16'($urandom_range(60, 13));
			cc = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(8, 1));
			lenmax = $urandom_range(8, 2);
			if (seg == 1)
				dv = 16'd255;
			if (seg == 2) begin
				cc     = 16'd255;
				tm     = 16'hFFFF;
				lenmax = 2;
			end
			write_reg(REG_DIVISOR, dv);
			write_reg(REG_TIMEOUT_LIMIT, tm);
			write_reg(REG_START_LEVEL, 16'($urandom_range(1)));
			write_reg(REG_CAPTURE_COUNT, cc);
			idle_en <= ($urandom_range(3) != 0);
			if (seg == 0 || $urandom_range(4) == 0)
				hold_reqs <= hold_reqs + 1;
			runs = (cfg_ccount > 8'd16) ? 1 : $urandom_range(6, 3);
			repeat (runs) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(12, 3))
						feed_one(1'($urandom_range(1)), 1'($urandom_range(1)));
				else
					push_run(($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(3),
						($urandom_range(6) == 0) ? $urandom_range(cfg_ccount + 2) : cfg_ccount,
						lenmax);
			end
			seg++;
		end
		settle();

		$display("sent %0d line samples over %0d register settings, %0d register writes",
			stim_items, seg + 4, reg_writes);
		$display("checked %0d results, %0d of them timeouts", results_seen, timeouts);
		if (errors == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pdc_pkg.sv
rtl/pdc_core.sv
rtl/pulse_duration_capture.sv
tb/sv/pulse_duration_capture_tb.sv
